// File: rtl/tadc_pkg.sv
// shared constants, ratio table and helpers for the thermistor temperature block
`timescale 1ns / 1ps

package tadc_pkg;

   localparam int TABLE_POINTS    = 23;
   localparam int IDX_W           = $clog2(TABLE_POINTS);
   localparam int ADC_BITS        = 10;
   localparam int RATIO_FRAC_BITS = 16;
   localparam int RATIO_W         = 8 + RATIO_FRAC_BITS;
   localparam int CSR_W           = 20;
   localparam int CSR_IDX_W       = 1;
   localparam int DEN_W           = CSR_W + ADC_BITS;
   localparam int NUM_W           = CSR_W + ADC_BITS + RATIO_FRAC_BITS;
   localparam int DIV_CNT_W       = $clog2(RATIO_W);
   localparam int TEMP_W          = 16;
   localparam int SUM_W           = RATIO_W + 3;

   // temperature of point 0 and step between points, Q8.8 degrees
   localparam int T_BASE   = -55 * 256;
   localparam int T_STEP   = 5 * 256;
   localparam int TEMP_MAX = 32767;
   localparam int TEMP_MIN = -32768;

   localparam logic [CSR_W-1:0] DIVIDER_RESET = CSR_W'(1000);
   localparam logic [CSR_W-1:0] NOMINAL_RESET = CSR_W'(10000);

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_DIVIDER = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_NOMINAL = CSR_IDX_W'(1);

   // resistance ratios of the table points in Q.24, -55 C to +55 C in 5 C steps
   localparam logic [31:0] RATIO_Q24 [TABLE_POINTS] = '{
      32'd2037760655, 32'd1416651342, 32'd993932607, 32'd703602885, 32'd502427288,
      32'd361834217,  32'd262412435,  32'd192367559, 32'd141784252, 32'd105573987,
      32'd78982100,   32'd59664803,   32'd45498132,  32'd34997273,  32'd27185801,
      32'd21278543,   32'd16777216,   32'd13324465,  32'd10614609,  32'd8512759,
      32'd6883021,    32'd5597383,    32'd4570617
   };

   localparam int          RATIO_SHIFT = 24 - RATIO_FRAC_BITS;
   localparam logic [31:0] ROUND_HALF  = 32'((64'd1 << RATIO_SHIFT) >> 1);

   // table point rounded to nearest into the ratio format
   function automatic logic [RATIO_W-1:0] point_ratio(input logic [IDX_W-1:0] idx);
      logic [31:0] sum;
      sum = RATIO_Q24[idx] + ROUND_HALF;
      return RATIO_W'(sum >> RATIO_SHIFT);
   endfunction

endpackage

// File: rtl/tadc_req_if.sv
// request channel: one converter sample
`timescale 1ns / 1ps

interface tadc_req_if;
   logic                          valid;
   logic                          ready;
   logic [tadc_pkg::ADC_BITS-1:0] adc_sample;

   modport source (output valid, output adc_sample, input ready);
   modport sink   (input valid, input adc_sample, output ready);
endinterface

// File: rtl/tadc_rsp_if.sv
// result channel: temperature and valid flag
`timescale 1ns / 1ps

interface tadc_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [tadc_pkg::TEMP_W-1:0] temperature;
   logic                        temp_valid;

   modport source (output valid, output temperature, output temp_valid, input ready);
   modport sink   (input valid, input temperature, input temp_valid, output ready);
endinterface

// File: rtl/tadc_ram.sv
// generic single-port-write ram with registered read
`timescale 1ns / 1ps

module tadc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/thermistor_adc_to_temperature_top.sv
// thermistor divider sample to q8.8 temperature by table lookup and interpolation
`timescale 1ns / 1ps

// channel   | direction | payload                              | handshake
// req_ch    | in        | adc_sample[9:0]                      | valid/ready
// rsp_ch    | out       | temperature[15:0] signed, temp_valid | valid/ready
// csr port  | in        | csr_index, csr_wdata[19:0]           | csr_wr_en, no wait
//
// one request at a time; the time taken is set by the 24-step shared restoring divider
// (run up to twice) and the table scan, one ram read per cycle over up to 23 points;
// a zero sample skips both
// after reset a fill writes the ratio table into the ram; no request is taken until it ends
// the result sits in an output register, so a new request is taken while it waits;
// a stalled result blocks only the delivery of the next one

module thermistor_adc_to_temperature_top (
   input  logic                           clock,
   input  logic                           reset,
   tadc_req_if.sink                       req_ch,
   tadc_rsp_if.source                     rsp_ch,
   input  logic                           csr_wr_en,
   input  logic [tadc_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [tadc_pkg::CSR_W-1:0]     csr_wdata
);

   localparam int IDX_W   = tadc_pkg::IDX_W;
   localparam int RATIO_W = tadc_pkg::RATIO_W;
   localparam int NUM_W   = tadc_pkg::NUM_W;
   localparam int DEN_W   = tadc_pkg::DEN_W;
   localparam int SUM_W   = tadc_pkg::SUM_W;
   localparam int TEMP_W  = tadc_pkg::TEMP_W;

   typedef enum logic [2:0] {
      ST_FILL,
      ST_IDLE,
      ST_MUL,
      ST_DLOAD,
      ST_DIV,
      ST_SCAN,
      ST_INTERP,
      ST_DONE
   } state_type;

   state_type                    state_ff;
   logic [tadc_pkg::CSR_W-1:0]   div_res_ff;
   logic [tadc_pkg::CSR_W-1:0]   nom_res_ff;
   logic [tadc_pkg::ADC_BITS-1:0] sample_ff;

   // table fill / scan address and read pipeline
   logic [IDX_W-1:0]             idx_ff;
   logic [IDX_W-1:0]             didx_ff;
   logic                         dv_ff;
   logic [RATIO_W-1:0]           ram_rd_data;

   // shared divider
   logic [NUM_W-1:0]             dvd_ff;
   logic [DEN_W-1:0]             dvs_ff;
   logic [DEN_W-1:0]             rem_ff;
   logic [RATIO_W-1:0]           lo_ff;
   logic [RATIO_W-1:0]           quot_ff;
   logic [tadc_pkg::DIV_CNT_W-1:0] cnt_ff;
   logic                         sat_ff;
   logic                         phase_ff;

   // lookup
   logic [RATIO_W-1:0]           ratio_ff;
   logic [RATIO_W-1:0]           prev_ff;
   logic [RATIO_W-1:0]           r2_ff;
   logic [IDX_W-1:0]             seg_ff;
   logic                         neg_ff;

   // pending result and output register
   logic [TEMP_W-1:0]            res_temp_ff;
   logic                         res_valid_ff;
   logic                         rsp_valid_ff;
   logic [TEMP_W-1:0]            rsp_temp_ff;
   logic                         rsp_tvalid_ff;

   // combinational
   logic [DEN_W:0]               div_trial;
   logic                         div_ge;
   logic [DEN_W:0]               div_diff;
   logic [DEN_W-1:0]             rem_in;
   logic [RATIO_W-1:0]           quot_in;
   logic [RATIO_W-1:0]           q_final;
   logic [DEN_W-1:0]             num_prod;
   logic [DEN_W-1:0]             den_prod;
   logic [tadc_pkg::ADC_BITS-1:0] sample_comp;
   logic [RATIO_W:0]             interp_a;
   logic [RATIO_W-1:0]           interp_mag;
   logic [RATIO_W-1:0]           interp_ad;
   logic [NUM_W-1:0]             interp_dvd;
   logic [SUM_W-1:0]             temp_base;
   logic [SUM_W-1:0]             q_ext;
   logic [SUM_W-1:0]             q_signed;
   logic [SUM_W-1:0]             t_sum;
   logic [TEMP_W-1:0]            temp_sat;

   tadc_ram #(
      .WIDTH (RATIO_W),
      .DEPTH (tadc_pkg::TABLE_POINTS)
   ) u_ratio_ram (
      .clock   (clock),
      .wr_en   (state_ff == ST_FILL),
      .wr_addr (idx_ff),
      .wr_data (tadc_pkg::point_ratio(idx_ff)),
      .rd_addr (idx_ff),
      .rd_data (ram_rd_data)
   );

   // one restoring step: bring in the next dividend bit, subtract if it fits
   always_comb begin
      div_trial = {rem_ff, lo_ff[RATIO_W-1]};
      div_ge    = div_trial >= {1'b0, dvs_ff};
      div_diff  = div_trial - {1'b0, dvs_ff};
      rem_in    = div_ge ? div_diff[DEN_W-1:0] : div_trial[DEN_W-1:0];
      quot_in   = {quot_ff[RATIO_W-2:0], div_ge};
      q_final   = sat_ff ? '1 : quot_in;
   end

   // ratio operands: divider * (full - sample) and sample * nominal
   always_comb begin
      sample_comp = '1 - sample_ff;
      num_prod    = DEN_W'(div_res_ff) * DEN_W'(sample_comp);
      den_prod    = DEN_W'(sample_ff) * DEN_W'(nom_res_ff);
   end

   // interpolation operands: q = round(|r1 - r| * 1280 / (r1 - r2)), sign of r1 - r
   always_comb begin
      interp_a   = {1'b0, prev_ff} - {1'b0, ratio_ff};
      interp_mag = interp_a[RATIO_W] ? RATIO_W'(-interp_a) : interp_a[RATIO_W-1:0];
      interp_ad  = prev_ff - r2_ff;
      interp_dvd = NUM_W'(interp_mag) * NUM_W'(tadc_pkg::T_STEP)
                 + NUM_W'(interp_ad >> 1);
   end

   // final temperature: segment start plus signed offset, saturated to 16 bits
   always_comb begin
      temp_base = SUM_W'(tadc_pkg::T_BASE) + SUM_W'(seg_ff) * SUM_W'(tadc_pkg::T_STEP);
      q_ext     = SUM_W'(q_final);
      q_signed  = neg_ff ? (~q_ext + SUM_W'(1)) : q_ext;
      t_sum     = temp_base + q_signed;
      if ($signed(t_sum) > $signed(SUM_W'(tadc_pkg::TEMP_MAX))) begin
         temp_sat = TEMP_W'(tadc_pkg::TEMP_MAX);
      end else if ($signed(t_sum) < $signed(SUM_W'(tadc_pkg::TEMP_MIN))) begin
         temp_sat = TEMP_W'(tadc_pkg::TEMP_MIN);
      end else begin
         temp_sat = t_sum[TEMP_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_FILL;
         idx_ff        <= '0;
         dv_ff         <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         div_res_ff    <= tadc_pkg::DIVIDER_RESET;
         nom_res_ff    <= tadc_pkg::NOMINAL_RESET;
      end else begin
         // register writes
         if (csr_wr_en) begin
            case (csr_index)
               tadc_pkg::CSR_DIVIDER: div_res_ff <= csr_wdata;
               tadc_pkg::CSR_NOMINAL: nom_res_ff <= csr_wdata;
               default: ;
            endcase
         end

         // the done state reloads or holds the output register itself
         if (rsp_ch.ready && state_ff != ST_DONE) begin
            rsp_valid_ff <= 1'b0;
         end

         case (state_ff)
            ST_FILL: begin
               if (idx_ff == IDX_W'(tadc_pkg::TABLE_POINTS - 1)) begin
                  idx_ff   <= '0;
                  state_ff <= ST_IDLE;
               end else begin
                  idx_ff <= idx_ff + IDX_W'(1);
               end
            end

            ST_IDLE: begin
               if (req_ch.valid) begin
                  sample_ff <= req_ch.adc_sample;
                  state_ff  <= ST_MUL;
               end
            end

            ST_MUL: begin
               dvd_ff   <= NUM_W'(num_prod) << tadc_pkg::RATIO_FRAC_BITS;
               dvs_ff   <= den_prod;
               phase_ff <= 1'b0;
               state_ff <= ST_DLOAD;
            end

            ST_DLOAD: begin
               if (dvs_ff == '0) begin
                  // zero sample or zero nominal resistance
                  res_temp_ff  <= '0;
                  res_valid_ff <= 1'b0;
                  state_ff     <= ST_DONE;
               end else begin
                  // quotient overflows the ratio width when the high part >= divisor
                  sat_ff   <= DEN_W'(dvd_ff[NUM_W-1:RATIO_W]) >= dvs_ff;
                  rem_ff   <= DEN_W'(dvd_ff[NUM_W-1:RATIO_W]);
                  lo_ff    <= dvd_ff[RATIO_W-1:0];
                  quot_ff  <= '0;
                  cnt_ff   <= '0;
                  state_ff <= ST_DIV;
               end
            end

            ST_DIV: begin
               rem_ff  <= rem_in;
               lo_ff   <= lo_ff << 1;
               quot_ff <= quot_in;
               cnt_ff  <= cnt_ff + tadc_pkg::DIV_CNT_W'(1);
               if (cnt_ff == tadc_pkg::DIV_CNT_W'(RATIO_W - 1)) begin
                  if (!phase_ff) begin
                     ratio_ff <= q_final;
                     idx_ff   <= '0;
                     dv_ff    <= 1'b0;
                     state_ff <= ST_SCAN;
                  end else begin
                     res_temp_ff  <= temp_sat;
                     res_valid_ff <= 1'b1;
                     state_ff     <= ST_DONE;
                  end
               end
            end

            ST_SCAN: begin
               // one read issued per cycle, data back in the next cycle
               didx_ff <= idx_ff;
               if (dv_ff && didx_ff != '0 && ram_rd_data <= ratio_ff) begin
                  // first point after point 0 at or below the ratio ends the segment
                  r2_ff    <= ram_rd_data;
                  seg_ff   <= didx_ff - IDX_W'(1);
                  dv_ff    <= 1'b0;
                  idx_ff   <= '0;
                  state_ff <= ST_INTERP;
               end else if (dv_ff && didx_ff == IDX_W'(tadc_pkg::TABLE_POINTS - 1)) begin
                  // hotter than the last point
                  res_temp_ff  <= '0;
                  res_valid_ff <= 1'b0;
                  dv_ff        <= 1'b0;
                  idx_ff       <= '0;
                  state_ff     <= ST_DONE;
               end else begin
                  if (idx_ff != IDX_W'(tadc_pkg::TABLE_POINTS - 1)) begin
                     idx_ff <= idx_ff + IDX_W'(1);
                  end
                  dv_ff <= 1'b1;
                  if (dv_ff) begin
                     prev_ff <= ram_rd_data;
                  end
               end
            end

            ST_INTERP: begin
               neg_ff   <= interp_a[RATIO_W];
               dvd_ff   <= interp_dvd;
               dvs_ff   <= DEN_W'(interp_ad);
               phase_ff <= 1'b1;
               state_ff <= ST_DLOAD;
            end

            ST_DONE: begin
               if (!rsp_valid_ff || rsp_ch.ready) begin
                  rsp_valid_ff  <= 1'b1;
                  rsp_temp_ff   <= res_temp_ff;
                  rsp_tvalid_ff <= res_valid_ff;
                  state_ff      <= ST_IDLE;
               end
            end

            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign req_ch.ready       = (state_ff == ST_IDLE);
   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.temperature = rsp_temp_ff;
   assign rsp_ch.temp_valid  = rsp_tvalid_ff;

endmodule
